// ----- design/lkhc_pkg.sv -----
// Package for the keyed LRU handle cache: field widths, request kinds,
// result record and parameter defaults. No dependencies.
`default_nettype none

package lkhc_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int KIND_W   = 2;
  localparam int TEXT_W   = 32;
  localparam int FONT_W   = 16;
  localparam int SIZE_W   = 8;
  localparam int HANDLE_W = 32;
  localparam int CFG_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NOP    = 2'd3
  } kind_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] found_handle;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;
  } res_t;

endpackage

`default_nettype wire

// ----- design/lru_keyed_handle_cache.sv -----
// Keyed LRU handle cache: slot registers, recency ranks and result queue.
// Depends on lkhc_pkg for widths, request kinds and the result record.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | kind, text_tag, font_id, font_size, new_handle
//   out     | output    | out_valid/out_stall| hit, found_handle, evicted, evicted_handle
//   cfg     | input     | cfg_we             | cfg_wdata (max_entries)
//
// One item per cycle while in_stall is low: the key compare over all slots and the rank
// update are done in the cycle the item is accepted, and its result lands on that edge in
// the output register, or in the one skid register while the output is stalled; in_stall
// rises only when both are full. Reset clears the valid bits, the count, the maximum and
// the queue; slot payload is not cleared and no sweep follows reset.
`default_nettype none

module lru_keyed_handle_cache
  import lkhc_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 cfg_we,
  input  wire [CFG_W-1:0]     cfg_wdata,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire [KIND_W-1:0]    in_kind,
  input  wire [TEXT_W-1:0]    in_text_tag,
  input  wire [FONT_W-1:0]    in_font_id,
  input  wire [SIZE_W-1:0]    in_font_size,
  input  wire [HANDLE_W-1:0]  in_new_handle,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic                out_hit,
  output logic [HANDLE_W-1:0] out_found_handle,
  output logic                out_evicted,
  output logic [HANDLE_W-1:0] out_evicted_handle
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > CFG_W) ? CW : CFG_W;

  logic [CFG_W-1:0]    max_r;
  logic [DEPTH-1:0]    valid_r, valid_nxt;
  logic [CW-1:0]       live_r, live_nxt;
  logic [TEXT_W-1:0]   text_r   [DEPTH];
  logic [TEXT_W-1:0]   text_nxt [DEPTH];
  logic [FONT_W-1:0]   font_r   [DEPTH];
  logic [FONT_W-1:0]   font_nxt [DEPTH];
  logic [SIZE_W-1:0]   size_r   [DEPTH];
  logic [SIZE_W-1:0]   size_nxt [DEPTH];
  logic [HANDLE_W-1:0] handle_r   [DEPTH];
  logic [HANDLE_W-1:0] handle_nxt [DEPTH];
  logic [AW-1:0]       age_r   [DEPTH];
  logic [AW-1:0]       age_nxt [DEPTH];
  logic [AW-1:0]       age_pro [DEPTH];

  logic                out_valid_r, skid_valid_r;
  res_t                out_r, skid_r, res;

  logic                in_fire, out_free;
  kind_t               kind;
  logic [DEPTH-1:0]    match, hit_oh, vict_cand, vict_oh, avail, free_oh;
  logic                hit_any;
  logic [AW-1:0]       hit_age, live_m1;
  logic [MW-1:0]       live_ext, max_ext;
  logic [CW-1:0]       live_after;
  logic                store_new;

  assign in_fire  = in_valid && !skid_valid_r;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = skid_valid_r;
  assign kind     = kind_t'(in_kind);
  assign live_m1  = AW'(live_r - CW'(1));
  assign live_ext = MW'(live_r);
  assign max_ext  = MW'(max_r);

  always_comb begin
    valid_nxt  = valid_r;
    live_nxt   = live_r;
    text_nxt   = text_r;
    font_nxt   = font_r;
    size_nxt   = size_r;
    handle_nxt = handle_r;
    age_nxt    = age_r;
    res        = '0;
    vict_cand  = '0;
    vict_oh    = '0;
    avail      = valid_r;
    free_oh    = '0;
    live_after = live_r;
    store_new  = 1'b0;
    hit_age    = '0;

    for (int i = 0; i < DEPTH; i++) begin
      match[i] = valid_r[i] && text_r[i] == in_text_tag && font_r[i] == in_font_id &&
                 size_r[i] == in_font_size;
    end
    hit_oh  = match & (~match + DEPTH'(1));
    hit_any = |match;
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_oh[i]) hit_age = hit_age | age_r[i];
    end
    // promote the hit slot: slots more recent than it age by one
    for (int i = 0; i < DEPTH; i++) begin
      if (hit_oh[i]) begin
        age_pro[i] = '0;
      end else if (valid_r[i] && age_r[i] < hit_age) begin
        age_pro[i] = age_r[i] + AW'(1);
      end else begin
        age_pro[i] = age_r[i];
      end
    end

    unique case (kind)
      KIND_LOOKUP: begin
        if (hit_any) begin
          age_nxt = age_pro;
          res.hit = 1'b1;
          for (int i = 0; i < DEPTH; i++) begin
            if (hit_oh[i]) res.found_handle = res.found_handle | handle_r[i];
          end
        end
      end
      KIND_INSERT: begin
        if (hit_any) begin
          age_nxt = age_pro;
          for (int i = 0; i < DEPTH; i++) begin
            if (hit_oh[i]) handle_nxt[i] = in_new_handle;
          end
          if (live_ext > max_ext) begin
            for (int i = 0; i < DEPTH; i++) begin
              vict_cand[i] = valid_r[i] && age_pro[i] == live_m1;
            end
            vict_oh     = vict_cand & (~vict_cand + DEPTH'(1));
            res.evicted = 1'b1;
            for (int i = 0; i < DEPTH; i++) begin
              if (vict_oh[i]) res.evicted_handle = res.evicted_handle | handle_nxt[i];
            end
            valid_nxt = valid_r & ~vict_oh;
            live_nxt  = live_r - CW'(vict_oh != '0);
          end
        end else begin
          store_new = 1'b1;
          if (live_ext >= max_ext || live_r == CW'(DEPTH)) begin
            res.evicted = 1'b1;
            if (live_r == '0) begin
              // nothing to drop: the new item itself is the one evicted
              res.evicted_handle = in_new_handle;
              store_new          = 1'b0;
            end else begin
              for (int i = 0; i < DEPTH; i++) begin
                vict_cand[i] = valid_r[i] && age_r[i] == live_m1;
              end
              vict_oh = vict_cand & (~vict_cand + DEPTH'(1));
              for (int i = 0; i < DEPTH; i++) begin
                if (vict_oh[i]) res.evicted_handle = res.evicted_handle | handle_r[i];
              end
              avail      = valid_r & ~vict_oh;
              live_after = live_r - CW'(vict_oh != '0);
            end
          end
          if (store_new) begin
            free_oh = ~avail & (avail + DEPTH'(1));
            for (int i = 0; i < DEPTH; i++) begin
              if (free_oh[i]) begin
                valid_nxt[i]  = 1'b1;
                text_nxt[i]   = in_text_tag;
                font_nxt[i]   = in_font_id;
                size_nxt[i]   = in_font_size;
                handle_nxt[i] = in_new_handle;
                age_nxt[i]    = '0;
              end else begin
                valid_nxt[i] = avail[i];
                if (avail[i]) age_nxt[i] = age_r[i] + AW'(1);
              end
            end
            live_nxt = live_after + CW'(free_oh != '0);
          end
        end
      end
      KIND_CLEAR: begin
        valid_nxt = '0;
        live_nxt  = '0;
      end
      KIND_NOP: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r        <= '0;
      valid_r      <= '0;
      live_r       <= '0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (cfg_we) max_r <= cfg_wdata;
      if (in_fire) begin
        valid_r <= valid_nxt;
        live_r  <= live_nxt;
      end
      if (out_free) begin
        out_valid_r  <= skid_valid_r || in_fire;
        skid_valid_r <= 1'b0;
      end else if (in_fire) begin
        skid_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      text_r   <= text_nxt;
      font_r   <= font_nxt;
      size_r   <= size_nxt;
      handle_r <= handle_nxt;
      age_r    <= age_nxt;
    end
    // drain skid first; hold the new item in skid while the output is stalled
    if (out_free) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_fire) begin
      skid_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_r.hit;
  assign out_found_handle   = out_r.found_handle;
  assign out_evicted        = out_r.evicted;
  assign out_evicted_handle = out_r.evicted_handle;

endmodule

`default_nettype wire

// ----- tb/lru_keyed_handle_cache_test.sv -----
// Self-checking testbench for lru_keyed_handle_cache: directed and random cache traffic,
// checked against an in-bench LRU prediction. Depends on lkhc_pkg and the cache RTL.
`timescale 1ns / 1ps

module lru_keyed_handle_cache_test;
  import lkhc_pkg::*;

  localparam int CACHE_DEPTH  = DEPTH_DEF;
  localparam int KEY_POOL     = 24;
  localparam int CHUNK_ITEMS  = 52;
  localparam int MAX_REPORTS  = 10;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 8;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind;
  logic [TEXT_W-1:0]   in_text_tag;
  logic [FONT_W-1:0]   in_font_id;
  logic [SIZE_W-1:0]   in_font_size;
  logic [HANDLE_W-1:0] in_new_handle;
  logic                out_valid;
  logic                out_stall;
  logic                out_hit;
  logic [HANDLE_W-1:0] out_found_handle;
  logic                out_evicted;
  logic [HANDLE_W-1:0] out_evicted_handle;

  lru_keyed_handle_cache #(.DEPTH(CACHE_DEPTH)) uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_text_tag       (in_text_tag),
    .in_font_id        (in_font_id),
    .in_font_size      (in_font_size),
    .in_new_handle     (in_new_handle),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_found_handle  (out_found_handle),
    .out_evicted       (out_evicted),
    .out_evicted_handle(out_evicted_handle)
  );

  // Predicted cache contents
  logic                slot_used   [CACHE_DEPTH];
  logic [TEXT_W-1:0]   slot_tag    [CACHE_DEPTH];
  logic [FONT_W-1:0]   slot_font   [CACHE_DEPTH];
  logic [SIZE_W-1:0]   slot_size   [CACHE_DEPTH];
  logic [HANDLE_W-1:0] slot_handle [CACHE_DEPTH];
  int                  slot_rank   [CACHE_DEPTH];
  int                  live_entries;
  logic [CFG_W-1:0]    max_keep;

  res_t expected_results[$];
  int   mismatch_count;
  int   send_idle_pct;
  int   stall_pct;

  logic [TEXT_W-1:0] pool_tag  [KEY_POOL];
  logic [FONT_W-1:0] pool_font [KEY_POOL];
  logic [SIZE_W-1:0] pool_size [KEY_POOL];

  int unsigned max_plan [16] = '{16, 3, 0, 9, 12, 1, 16, 5, 20, 7, 2, 14, 6, 31, 11, 4};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  function automatic int find_slot(input logic [TEXT_W-1:0] tag, input logic [FONT_W-1:0] font,
                                   input logic [SIZE_W-1:0] size);
    for (int i = 0; i < CACHE_DEPTH; i++)
      if (slot_used[i] && slot_tag[i] == tag && slot_font[i] == font && slot_size[i] == size)
        return i;
    return -1;
  endfunction

  // Age every entry newer than slot s, then make s the newest.
  function automatic void make_newest(input int s);
    int prior;
    prior = slot_rank[s];
    for (int i = 0; i < CACHE_DEPTH; i++)
      if (slot_used[i] && i != s && slot_rank[i] < prior)
        slot_rank[i]++;
    slot_rank[s] = 0;
  endfunction

  function automatic logic [HANDLE_W-1:0] drop_oldest();
    int oldest;
    oldest = -1;
    for (int i = 0; i < CACHE_DEPTH; i++)
      if (slot_used[i] && (oldest < 0 || slot_rank[i] > slot_rank[oldest]))
        oldest = i;
    if (oldest < 0)
      return '0;
    slot_used[oldest] = 1'b0;
    if (live_entries > 0)
      live_entries--;
    return slot_handle[oldest];
  endfunction

  function automatic res_t predict_access(input kind_t kind, input logic [TEXT_W-1:0] tag,
                                          input logic [FONT_W-1:0] font,
                                          input logic [SIZE_W-1:0] size,
                                          input logic [HANDLE_W-1:0] handle);
    res_t r;
    int   s;
    int   free_slot;
    r = '0;
    case (kind)
      KIND_LOOKUP: begin
        s = find_slot(tag, font, size);
        if (s >= 0) begin
          make_newest(s);
          r.hit          = 1'b1;
          r.found_handle = slot_handle[s];
        end
      end
      KIND_INSERT: begin
        s = find_slot(tag, font, size);
        if (s >= 0) begin
          slot_handle[s] = handle;
          make_newest(s);
          if (live_entries > int'(max_keep)) begin
            r.evicted        = 1'b1;
            r.evicted_handle = drop_oldest();
          end
        end else begin
          if (live_entries + 1 > int'(max_keep) || live_entries + 1 > CACHE_DEPTH) begin
            r.evicted = 1'b1;
            // An empty cache with no room drops the new entry itself.
            if (live_entries == 0) begin
              r.evicted_handle = handle;
              return r;
            end
            r.evicted_handle = drop_oldest();
          end
          free_slot = -1;
          for (int i = 0; i < CACHE_DEPTH; i++)
            if (!slot_used[i] && free_slot < 0)
              free_slot = i;
          if (free_slot >= 0) begin
            for (int j = 0; j < CACHE_DEPTH; j++)
              if (slot_used[j])
                slot_rank[j]++;
            slot_used[free_slot]   = 1'b1;
            slot_tag[free_slot]    = tag;
            slot_font[free_slot]   = font;
            slot_size[free_slot]   = size;
            slot_handle[free_slot] = handle;
            slot_rank[free_slot]   = 0;
            live_entries++;
          end
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < CACHE_DEPTH; i++)
          slot_used[i] = 1'b0;
        live_entries = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_request(input kind_t kind, input logic [TEXT_W-1:0] tag,
                              input logic [FONT_W-1:0] font, input logic [SIZE_W-1:0] size,
                              input logic [HANDLE_W-1:0] handle);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_text_tag   <= tag;
    in_font_id    <= font;
    in_font_size  <= size;
    in_new_handle <= handle;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(predict_access(kind, tag, font, size, handle));
  endtask

  task automatic send_pooled(input kind_t kind, input int idx, input logic [HANDLE_W-1:0] handle);
    send_request(kind, pool_tag[idx], pool_font[idx], pool_size[idx], handle);
  endtask

  // Write the limit only once every pending result has drained.
  task automatic set_max_entries(input logic [CFG_W-1:0] value);
    in_valid <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    max_keep = value;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk)
    out_stall <= ($urandom_range(99) < stall_pct);

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input logic [HANDLE_W-1:0] want,
                                      input logic [HANDLE_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result with nothing pending: hit=%0b found=%h evicted=%0b handle=%h",
                   $time, out_hit, out_found_handle, out_evicted, out_evicted_handle);
      end else begin
        want = expected_results.pop_front();
        check_field("hit", HANDLE_W'(want.hit), HANDLE_W'(out_hit));
        check_field("found_handle", want.found_handle, out_found_handle);
        check_field("evicted", HANDLE_W'(want.evicted), HANDLE_W'(out_evicted));
        check_field("evicted_handle", want.evicted_handle, out_evicted_handle);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------- tests

  // Reset limit of zero: every new insert evicts itself.
  task automatic test_zero_limit();
    send_pooled(KIND_INSERT, 1, '1);
    send_pooled(KIND_LOOKUP, 1, '0);
    send_request(KIND_NOP, '1, '1, '1, '1);
    send_pooled(KIND_INSERT, 0, '0);
    send_request(KIND_CLEAR, '1, '1, '1, '1);
  endtask

  task automatic test_recency_order();
    set_max_entries(5'd2);
    send_pooled(KIND_INSERT, 0, '0);
    send_pooled(KIND_INSERT, 1, '1);
    send_pooled(KIND_LOOKUP, 0, '1);
    send_pooled(KIND_INSERT, 2, 32'h1234_5678);
    send_pooled(KIND_INSERT, 0, 32'hA5A5_5A5A);  // present key: update in place
    send_pooled(KIND_LOOKUP, 2, '0);
    send_pooled(KIND_LOOKUP, 1, '0);
    send_request(KIND_CLEAR, '0, '0, '0, '0);
    send_pooled(KIND_LOOKUP, 0, '0);
  endtask

  // Lowering the limit sheds only one entry per insert.
  task automatic test_lowered_limit();
    set_max_entries(5'd3);
    send_pooled(KIND_INSERT, 3, $urandom);
    send_pooled(KIND_INSERT, 4, $urandom);
    send_pooled(KIND_INSERT, 5, $urandom);
    set_max_entries(5'd1);
    send_pooled(KIND_INSERT, 4, $urandom);
    send_pooled(KIND_INSERT, 6, $urandom);
    send_pooled(KIND_LOOKUP, 4, '0);
    send_pooled(KIND_LOOKUP, 3, '0);
  endtask

  // Limit above the slot count: the store caps at its depth.
  task automatic test_capacity();
    set_max_entries(5'd31);
    send_request(KIND_CLEAR, $urandom, FONT_W'($urandom), SIZE_W'($urandom), $urandom);
    for (int k = 0; k < CACHE_DEPTH + 2; k++)
      send_pooled(KIND_INSERT, k, $urandom);
    send_pooled(KIND_LOOKUP, 0, '0);
    send_pooled(KIND_LOOKUP, CACHE_DEPTH + 1, '0);
  endtask

  task automatic test_random_traffic(input int phase);
    int pick;
    for (int c = 0; c < 4; c++) begin
      set_max_entries(max_plan[phase * 4 + c][CFG_W-1:0]);
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 44)
          send_pooled(KIND_LOOKUP, $urandom_range(KEY_POOL - 1), $urandom);
        else if (pick < 84)
          send_pooled(KIND_INSERT, $urandom_range(KEY_POOL - 1), $urandom);
        else if (pick < 87)
          send_request(KIND_CLEAR, $urandom, FONT_W'($urandom), SIZE_W'($urandom), $urandom);
        else if (pick < 90)
          send_request(KIND_NOP, $urandom, FONT_W'($urandom), SIZE_W'($urandom), $urandom);
        else
          send_request(kind_t'($urandom_range(1)), $urandom, FONT_W'($urandom),
                       SIZE_W'($urandom), $urandom);
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_kind        = KIND_NOP;
    in_text_tag    = '0;
    in_font_id     = '0;
    in_font_size   = '0;
    in_new_handle  = '0;
    out_stall      = 1'b0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    live_entries   = 0;
    max_keep       = '0;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_rank[i] = 0;
    end

    // Key pool: all-zero and all-one keys, plus near-miss keys sharing parts.
    for (int k = 0; k < KEY_POOL; k++) begin
      pool_tag[k]  = $urandom;
      pool_font[k] = FONT_W'($urandom);
      pool_size[k] = SIZE_W'($urandom);
    end
    pool_tag[0] = '0;  pool_font[0] = '0;  pool_size[0] = '0;
    pool_tag[1] = '1;  pool_font[1] = '1;  pool_size[1] = '1;
    pool_tag[3] = pool_tag[2];  pool_font[3] = pool_font[2];  pool_size[3] = pool_size[2] ^ 8'h01;
    pool_tag[4] = pool_tag[2];  pool_font[4] = pool_font[2] ^ 16'h0001;  pool_size[4] = pool_size[2];

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_limit();
    test_recency_order();
    test_lowered_limit();
    test_capacity();

    send_idle_pct = 0;   stall_pct = 0;   test_random_traffic(0);
    send_idle_pct = 76;  stall_pct = 0;   test_random_traffic(1);
    send_idle_pct = 0;   stall_pct = 76;  test_random_traffic(2);
    send_idle_pct = 28;  stall_pct = 28;  test_random_traffic(3);

    in_valid <= 1'b0;
    while (expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
